/* design/assert_macros.svh */
// Assertion macros shared by the design files.
// Depends on a clock named clk and an active-low reset named arst_n in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

/* design/bpvr_pkg.sv */
// Package for the best price venue router: sizes, codes and beat types.
// No dependencies; used by the top level by scoped names.
package bpvr_pkg;

	localparam int NUM_VENUES  = 8;
	localparam int NUM_SYMBOLS = 1024;
	localparam int PRICE_BITS  = 32;
	localparam int QTY_BITS    = 32;
	localparam int VENUE_W     = 3;
	localparam int SYMBOL_W    = 10;
	localparam int REASON_W    = 3;

	localparam int VEN_AW = $clog2(NUM_VENUES);
	localparam int SYM_AW = $clog2(NUM_SYMBOLS);

	localparam logic CMD_UPDATE = 1'b0;
	localparam logic CMD_ROUTE  = 1'b1;

	localparam logic SIDE_BUY  = 1'b0;
	localparam logic SIDE_SELL = 1'b1;

	localparam logic [REASON_W-1:0] RSN_STORED   = REASON_W'(0);
	localparam logic [REASON_W-1:0] RSN_REJECTED = REASON_W'(1);
	localparam logic [REASON_W-1:0] RSN_LOW_ASK  = REASON_W'(2);
	localparam logic [REASON_W-1:0] RSN_HIGH_BID = REASON_W'(3);
	localparam logic [REASON_W-1:0] RSN_NO_ASK   = REASON_W'(4);
	localparam logic [REASON_W-1:0] RSN_NO_BID   = REASON_W'(5);

	typedef struct packed {
		logic                         command;
		logic [VENUE_W-1:0]           venue;
		logic [SYMBOL_W-1:0]          instr_id;
		logic signed [PRICE_BITS-1:0] bid_px;
		logic [QTY_BITS-1:0]          bid_qty;
		logic signed [PRICE_BITS-1:0] ask_px;
		logic [QTY_BITS-1:0]          ask_qty;
		logic                         side;
		logic [QTY_BITS-1:0]          order_qty;
	} req_t;

	typedef struct packed {
		logic                         update_accepted;
		logic                         routeable;
		logic [VENUE_W-1:0]           chosen_venue;
		logic [SYMBOL_W-1:0]          out_symbol;
		logic                         out_side;
		logic signed [PRICE_BITS-1:0] route_px;
		logic [QTY_BITS-1:0]          out_qty;
		logic [REASON_W-1:0]          reason_code;
	} rsp_t;

	// One venue's top of book inside a symbol row.
	typedef struct packed {
		logic                         valid;
		logic signed [PRICE_BITS-1:0] bid_px;
		logic [QTY_BITS-1:0]          bid_qty;
		logic signed [PRICE_BITS-1:0] ask_px;
		logic [QTY_BITS-1:0]          ask_qty;
	} book_entry_t;

	// All venues of one symbol share one memory word.
	typedef book_entry_t [NUM_VENUES-1:0] book_row_t;

	localparam int ROW_W = $bits(book_row_t);

endpackage

/* design/bpvr_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module bpvr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* design/best_price_venue_router_top.sv */
// Top level of the best price venue router: book table, update check and router.
// Depends on bpvr_pkg, bpvr_ram and assert_macros.svh.
//
// The block keeps the top of book (bid and ask price and quantity) for every venue and
// symbol in one RAM, one word per symbol holding all venues. An update beat (command 0)
// stores one venue's entry after checking it: nonzero in-range symbol, in-range venue,
// both prices positive, bid not above ask; otherwise it is rejected and the table is left
// alone. A route beat (command 1) picks, for a buy, the valid venue with the lowest ask and,
// for a sell, the one with the highest bid; equal prices go to the lower venue number. Each
// request beat gives exactly one response beat. An item first has the RAM read of the
// symbol's row, then the venue compare tree and, for an update, the write back of the
// merged row, which waits while the output register is full and stalled; a new request is
// taken in the cycle after a result is produced, even while that result still waits in
// the output register. After reset the block runs a clearing pass over the table, one row
// per cycle over all NUM_SYMBOLS (1024) rows, and holds req_stall high until it is done.
`include "assert_macros.svh"

module best_price_venue_router_top (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  bpvr_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output bpvr_pkg::rsp_t  rsp
);

	localparam int LEAVES = 1 << bpvr_pkg::VEN_AW;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC
	} state_t;

	state_t                         state_q;
	logic [bpvr_pkg::SYM_AW-1:0]    clr_q;
	bpvr_pkg::req_t                 item_q;
	bpvr_pkg::rsp_t                 rsp_q;
	logic                           rsp_valid_q;

	logic                           ram_we;
	logic [bpvr_pkg::SYM_AW-1:0]    ram_waddr;
	logic [bpvr_pkg::ROW_W-1:0]     ram_wdata;
	logic                           ram_re;
	logic [bpvr_pkg::ROW_W-1:0]     ram_rdata;

	bpvr_pkg::book_row_t            row;
	bpvr_pkg::book_row_t            new_row;
	logic                           sym_ok;
	logic                           upd_ok;
	logic                           exec_fire;
	bpvr_pkg::rsp_t                 rsp_next;

	// Compare tree: node 1 is the root, leaves sit at LEAVES + venue.
	logic                                  node_vld [1:2*LEAVES-1];
	logic signed [bpvr_pkg::PRICE_BITS-1:0] node_px [1:2*LEAVES-1];
	logic [bpvr_pkg::VEN_AW-1:0]           node_ven [1:2*LEAVES-1];

	assign req_stall = (state_q != S_IDLE);
	assign ram_re    = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// The response register must be free (or draining) before the result is written.
	assign exec_fire = (state_q == S_EXEC) && (!rsp_valid_q || !rsp_stall);

	assign row = bpvr_pkg::book_row_t'(ram_rdata);

	assign sym_ok = 32'(item_q.instr_id) < 32'(bpvr_pkg::NUM_SYMBOLS);

	assign upd_ok = (item_q.instr_id != '0) && sym_ok &&
		(32'(item_q.venue) < 32'(bpvr_pkg::NUM_VENUES)) &&
		(item_q.bid_px > 0) && (item_q.ask_px > 0) &&
		(item_q.bid_px <= item_q.ask_px);

	// Merge the update into the row just read; the other venues keep their contents.
	always_comb begin
		new_row = row;
		new_row[item_q.venue[bpvr_pkg::VEN_AW-1:0]] = '{
			valid:   1'b1,
			bid_px:  item_q.bid_px,
			bid_qty: item_q.bid_qty,
			ask_px:  item_q.ask_px,
			ask_qty: item_q.ask_qty
		};
	end

	// Clearing pass owns the write port after reset; later only updates write.
	always_comb begin
		if (state_q == S_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else begin
			ram_we    = exec_fire && (item_q.command == bpvr_pkg::CMD_UPDATE) && upd_ok;
			ram_waddr = item_q.instr_id[bpvr_pkg::SYM_AW-1:0];
			ram_wdata = bpvr_pkg::ROW_W'(new_row);
		end
	end

	bpvr_ram #(
		.WIDTH (bpvr_pkg::ROW_W),
		.DEPTH (bpvr_pkg::NUM_SYMBOLS)
	) u_book_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (req.instr_id[bpvr_pkg::SYM_AW-1:0]),
		.rdata (ram_rdata)
	);

	// Best price search: right child wins only when strictly better, so ties keep
	// the lower venue.
	always_comb begin
		for (int v = 0; v < LEAVES; v++) begin
			if (v < bpvr_pkg::NUM_VENUES) begin
				node_vld[LEAVES + v] = row[v].valid && sym_ok;
				node_px[LEAVES + v]  = (item_q.side == bpvr_pkg::SIDE_SELL) ?
					row[v].bid_px : row[v].ask_px;
			end else begin
				node_vld[LEAVES + v] = 1'b0;
				node_px[LEAVES + v]  = '0;
			end
			node_ven[LEAVES + v] = bpvr_pkg::VEN_AW'(v);
		end
		for (int n = LEAVES - 1; n >= 1; n--) begin
			if (node_vld[2*n+1] && (!node_vld[2*n] ||
				((item_q.side == bpvr_pkg::SIDE_SELL) ?
					(node_px[2*n+1] > node_px[2*n]) :
					(node_px[2*n+1] < node_px[2*n])))) begin
				node_vld[n] = 1'b1;
				node_px[n]  = node_px[2*n+1];
				node_ven[n] = node_ven[2*n+1];
			end else begin
				node_vld[n] = node_vld[2*n];
				node_px[n]  = node_px[2*n];
				node_ven[n] = node_ven[2*n];
			end
		end
	end

	// Build the response beat.
	always_comb begin
		rsp_next = '0;
		rsp_next.out_symbol = item_q.instr_id;
		if (item_q.command == bpvr_pkg::CMD_UPDATE) begin
			rsp_next.update_accepted = upd_ok;
			rsp_next.reason_code     = upd_ok ? bpvr_pkg::RSN_STORED : bpvr_pkg::RSN_REJECTED;
		end else begin
			rsp_next.out_side = item_q.side;
			rsp_next.out_qty  = item_q.order_qty;
			if (node_vld[1]) begin
				rsp_next.routeable    = 1'b1;
				rsp_next.chosen_venue = bpvr_pkg::VENUE_W'(node_ven[1]);
				rsp_next.route_px     = node_px[1];
				rsp_next.reason_code  = (item_q.side == bpvr_pkg::SIDE_SELL) ?
					bpvr_pkg::RSN_HIGH_BID : bpvr_pkg::RSN_LOW_ASK;
			end else begin
				rsp_next.reason_code  = (item_q.side == bpvr_pkg::SIDE_SELL) ?
					bpvr_pkg::RSN_NO_BID : bpvr_pkg::RSN_NO_ASK;
			end
		end
	end

	// Sequencer: clear the table, then take one item, read its row, finish it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			item_q      <= '0;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (exec_fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == bpvr_pkg::SYM_AW'(bpvr_pkg::NUM_SYMBOLS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						item_q  <= req;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (exec_fire) begin
						rsp_q   <= rsp_next;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_CLEAR;
				end
			endcase
		end
	end

	`ASSERT_NEXT(a_accept_to_exec, req_valid && !req_stall, state_q == S_EXEC)
	`ASSERT_IMPL(a_route_no_write, (state_q == S_EXEC) && (item_q.command == bpvr_pkg::CMD_ROUTE), !ram_we)
	`ASSERT_IMPL(a_routed_reason, rsp_valid_q && rsp_q.routeable, (rsp_q.reason_code == bpvr_pkg::RSN_LOW_ASK) || (rsp_q.reason_code == bpvr_pkg::RSN_HIGH_BID))
	`ASSERT_IMPL(a_stored_reason, rsp_valid_q && rsp_q.update_accepted, (rsp_q.reason_code == bpvr_pkg::RSN_STORED) && !rsp_q.routeable)

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for best_price_venue_router_top: directed and random update and route beats.
// Depends on bpvr_pkg and the design top level; keeps its own price book to predict every response.
module tb;

	localparam int RANDOM_ORDERS = 750;
	localparam int TAIL_CYCLES   = 20;
	localparam int LONG_HOLD     = 400;

	typedef logic signed [bpvr_pkg::PRICE_BITS-1:0] px_t;

	// One stimulus beat plus a flag that makes the sender wait for an empty pipe first.
	typedef struct {
		bpvr_pkg::req_t beat;
		bit             wait_quiet;
	} order_slot_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	bpvr_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	bpvr_pkg::rsp_t rsp;

	// Mirror of the top-of-book table. Quantities never come back out, so keep prices only.
	bit  book_live [bpvr_pkg::NUM_VENUES][bpvr_pkg::NUM_SYMBOLS];
	px_t book_bid  [bpvr_pkg::NUM_VENUES][bpvr_pkg::NUM_SYMBOLS];
	px_t book_ask  [bpvr_pkg::NUM_VENUES][bpvr_pkg::NUM_SYMBOLS];

	order_slot_t    order_feed[$];
	bpvr_pkg::rsp_t answers_due[$];
	int             order_total = 0;
	int             orders_taken = 0;
	int             mismatch_count = 0;
	bit             nothing_due = 1'b1;

	// Pacing state for both sides.
	int feed_gap = 0;
	int feed_calm = 0;
	int hold_left = 0;
	int rsp_calm = 0;
	int answers_seen = 0;
	bit long_hold_done = 1'b0;

	best_price_venue_router_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #1 clk = ~clk;

	// Apply one request to the mirrored book and return the response it must produce.
	// Updates are checked and stored; routes scan every venue of the symbol, keeping the
	// first venue on a tie since only a strictly better price replaces the best so far.
	function automatic bpvr_pkg::rsp_t apply_to_book(bpvr_pkg::req_t r);
		bpvr_pkg::rsp_t a;
		bit   ok;
		bit   found;
		bit   better;
		int   best_v;
		px_t  best_px;
		px_t  p;
		a = '0;
		a.out_symbol = r.instr_id;
		if (r.command == bpvr_pkg::CMD_UPDATE) begin
			ok = r.instr_id != '0 && int'(r.instr_id) < bpvr_pkg::NUM_SYMBOLS
				&& int'(r.venue) < bpvr_pkg::NUM_VENUES
				&& $signed(r.bid_px) > 0 && $signed(r.ask_px) > 0
				&& $signed(r.bid_px) <= $signed(r.ask_px);
			if (ok) begin
				book_live[r.venue][r.instr_id] = 1'b1;
				book_bid[r.venue][r.instr_id] = r.bid_px;
				book_ask[r.venue][r.instr_id] = r.ask_px;
				a.update_accepted = 1'b1;
				a.reason_code = bpvr_pkg::RSN_STORED;
			end else begin
				a.reason_code = bpvr_pkg::RSN_REJECTED;
			end
			return a;
		end
		a.out_side = r.side;
		a.out_qty = r.order_qty;
		found = 1'b0;
		best_v = 0;
		best_px = '0;
		if (int'(r.instr_id) < bpvr_pkg::NUM_SYMBOLS) begin
			for (int v = 0; v < bpvr_pkg::NUM_VENUES; v++) begin
				if (book_live[v][r.instr_id]) begin
					p = (r.side == bpvr_pkg::SIDE_SELL) ?
						book_bid[v][r.instr_id] : book_ask[v][r.instr_id];
					better = (r.side == bpvr_pkg::SIDE_SELL) ? (p > best_px) : (p < best_px);
					if (!found || better) begin
						found = 1'b1;
						best_v = v;
						best_px = p;
					end
				end
			end
		end
		if (found) begin
			a.routeable = 1'b1;
			a.chosen_venue = bpvr_pkg::VENUE_W'(best_v);
			a.route_px = best_px;
			a.reason_code = (r.side == bpvr_pkg::SIDE_SELL) ?
				bpvr_pkg::RSN_HIGH_BID : bpvr_pkg::RSN_LOW_ASK;
		end else begin
			a.reason_code = (r.side == bpvr_pkg::SIDE_SELL) ?
				bpvr_pkg::RSN_NO_BID : bpvr_pkg::RSN_NO_ASK;
		end
		return a;
	endfunction

	// Fill every field with noise; the builders below overwrite what matters.
	function automatic bpvr_pkg::req_t any_beat();
		bpvr_pkg::req_t r;
		r.command = 1'($urandom);
		r.venue = bpvr_pkg::VENUE_W'($urandom);
		r.instr_id = bpvr_pkg::SYMBOL_W'($urandom);
		r.bid_px = $urandom;
		r.bid_qty = $urandom;
		r.ask_px = $urandom;
		r.ask_qty = $urandom;
		r.side = 1'($urandom);
		r.order_qty = $urandom;
		return r;
	endfunction

	function automatic bpvr_pkg::req_t mk_update(logic [bpvr_pkg::VENUE_W-1:0] ven,
			logic [bpvr_pkg::SYMBOL_W-1:0] sym, px_t bid, px_t ask);
		bpvr_pkg::req_t r;
		r = any_beat();
		r.command = bpvr_pkg::CMD_UPDATE;
		r.venue = ven;
		r.instr_id = sym;
		r.bid_px = bid;
		r.ask_px = ask;
		return r;
	endfunction

	function automatic bpvr_pkg::req_t mk_route(logic [bpvr_pkg::SYMBOL_W-1:0] sym, logic sd,
			logic [bpvr_pkg::QTY_BITS-1:0] qty);
		bpvr_pkg::req_t r;
		r = any_beat();
		r.command = bpvr_pkg::CMD_ROUTE;
		r.instr_id = sym;
		r.side = sd;
		r.order_qty = qty;
		return r;
	endfunction

	// Draw a well-formed quote: tiny prices to force ties, a tight band, or the full range.
	function automatic void pick_quote(output px_t bid, output px_t ask);
		px_t a;
		px_t b;
		int unsigned base;
		case ($urandom_range(0, 2))
			0: begin
				a = $urandom_range(1, 12);
				b = $urandom_range(1, 12);
			end
			1: begin
				base = $urandom_range(1, 32'h7FFF_FF00);
				a = base + $urandom_range(0, 24);
				b = base + $urandom_range(0, 24);
			end
			default: begin
				a = $urandom_range(1, 32'h7FFF_FFFF);
				b = $urandom_range(1, 32'h7FFF_FFFF);
			end
		endcase
		if (a > b) begin
			bid = b;
			ask = a;
		end else begin
			bid = a;
			ask = b;
		end
	endfunction

	// Idle length for one side: mostly none, some short, a few long, and calm stretches.
	function automatic int idle_run(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			calm = $urandom_range(30, 90);
			return 0;
		end
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	task automatic queue_order(bpvr_pkg::req_t b, bit quiet = 1'b0);
		order_slot_t s;
		s.beat = b;
		s.wait_quiet = quiet;
		order_feed = {order_feed, s};
		order_total++;
	endtask

	task automatic log_mismatch(string what);
		mismatch_count++;
		$display("[%0t] mismatch: %s", $time, what);
	endtask

	task automatic compare_field(string field, logic [63:0] got, logic [63:0] want);
		if (got !== want)
			log_mismatch($sformatf("%s got %0h want %0h", field, got, want));
	endtask

	// Request driver: predict each accepted beat, then present the next one or idle.
	// Hold the payload while the block stalls; only advance once the beat is taken.
	always @(posedge clk) begin : drive_orders
		order_slot_t nxt;
		bit took;
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			took = req_valid && !req_stall;
			if (took) begin
				answers_due = {answers_due, apply_to_book(req)};
				orders_taken++;
			end
			if (!req_valid || took) begin
				if (feed_gap > 0) begin
					feed_gap--;
					req_valid <= 1'b0;
				end else if (order_feed.size() > 0
						&& !(order_feed[0].wait_quiet && (took || !nothing_due))) begin
					nxt = order_feed.pop_front();
					req <= nxt.beat;
					req_valid <= 1'b1;
					feed_gap = idle_run(feed_calm);
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Response pacing: random stalls, plus one long hold-off once traffic is flowing so
	// the block backs up and stalls its request side while the sender keeps offering.
	always @(posedge clk) begin : pace_answers
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall)
				answers_seen++;
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else if (!long_hold_done && answers_seen >= 150) begin
				long_hold_done = 1'b1;
				hold_left = LONG_HOLD - 1;
				rsp_stall <= 1'b1;
			end else begin
				hold_left = idle_run(rsp_calm);
				if (hold_left > 0) begin
					hold_left--;
					rsp_stall <= 1'b1;
				end else begin
					rsp_stall <= 1'b0;
				end
			end
		end
	end

	// Response monitor: every accepted beat must match the oldest outstanding prediction.
	always @(posedge clk) begin : check_answers
		bpvr_pkg::rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (answers_due.size() == 0) begin
				log_mismatch($sformatf("response for symbol %0d with nothing outstanding",
					rsp.out_symbol));
			end else begin
				want = answers_due.pop_front();
				compare_field("update_accepted", rsp.update_accepted, want.update_accepted);
				compare_field("routeable", rsp.routeable, want.routeable);
				compare_field("chosen_venue", rsp.chosen_venue, want.chosen_venue);
				compare_field("out_symbol", rsp.out_symbol, want.out_symbol);
				compare_field("out_side", rsp.out_side, want.out_side);
				compare_field("route_px", rsp.route_px, want.route_px);
				compare_field("out_qty", rsp.out_qty, want.out_qty);
				compare_field("reason_code", rsp.reason_code, want.reason_code);
			end
		end
	end

	// Sample the outstanding count away from the clock edge so the driver reads it race-free.
	always @(negedge clk)
		nothing_due <= (answers_due.size() == 0);

	initial begin : run_test
		logic [bpvr_pkg::SYMBOL_W-1:0] hot_syms[6];
		logic [bpvr_pkg::SYMBOL_W-1:0] sym;
		bpvr_pkg::req_t beat;
		px_t bid;
		px_t ask;
		int unsigned hi;
		int pick;
		bit quiet;

		// Directed part: empty book, every reject reason, price extremes and tie-breaks.
		queue_order(mk_route(10'd5, bpvr_pkg::SIDE_BUY, 32'd100));
		queue_order(mk_route(10'd5, bpvr_pkg::SIDE_SELL, '1));
		queue_order(mk_update(3'd1, '0, 32'sd10, 32'sd20));
		queue_order(mk_route('0, bpvr_pkg::SIDE_BUY, '0));
		queue_order(mk_update(3'd2, 10'd5, 32'sd0, 32'sd20));
		queue_order(mk_update(3'd2, 10'd5, 32'sd10, -32'sd1));
		queue_order(mk_update(3'd2, 10'd5, 32'h8000_0000, 32'sd5));
		queue_order(mk_update(3'd2, 10'd5, 32'sd21, 32'sd20));
		queue_order(mk_update(3'd7, 10'h3FF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
		queue_order(mk_update(3'd0, 10'h3FF, 32'sd1, 32'h7FFF_FFFF));
		// equal asks on venues 0 and 7: the lower venue must win the buy
		queue_order(mk_route(10'h3FF, bpvr_pkg::SIDE_BUY, '1));
		queue_order(mk_route(10'h3FF, bpvr_pkg::SIDE_SELL, '0));
		queue_order(mk_update(3'd3, 10'd1, 32'sd100, 32'sd105));
		queue_order(mk_update(3'd5, 10'd1, 32'sd102, 32'sd104));
		queue_order(mk_update(3'd2, 10'd1, 32'sd102, 32'sd104));
		queue_order(mk_route(10'd1, bpvr_pkg::SIDE_BUY, 32'd7));
		queue_order(mk_route(10'd1, bpvr_pkg::SIDE_SELL, 32'd7));
		// overwrite venue 2 so venue 5 takes both sides
		queue_order(mk_update(3'd2, 10'd1, 32'sd90, 32'sd110));
		queue_order(mk_route(10'd1, bpvr_pkg::SIDE_BUY, 32'd8));
		queue_order(mk_route(10'd1, bpvr_pkg::SIDE_SELL, 32'd8));
		// rejected updates must have left symbol 5 empty
		queue_order(mk_route(10'd5, bpvr_pkg::SIDE_SELL, 32'd9));

		// Random part: mostly good quotes and routes on a small set of hot symbols,
		// the rest rejects, routes to cold symbols and raw noise.
		for (int k = 0; k < RANDOM_ORDERS; k++) begin
			if (k % 150 == 0) begin
				foreach (hot_syms[i])
					hot_syms[i] = bpvr_pkg::SYMBOL_W'(
						$urandom_range(1, bpvr_pkg::NUM_SYMBOLS - 1));
			end
			quiet = (k == 0) || ($urandom_range(0, 99) == 0);
			sym = hot_syms[$urandom_range(0, 5)];
			pick = $urandom_range(0, 99);
			pick_quote(bid, ask);
			if (pick < 45) begin
				beat = mk_update(bpvr_pkg::VENUE_W'($urandom), sym, bid, ask);
			end else if (pick < 85) begin
				beat = mk_route(sym, 1'($urandom), $urandom);
			end else begin
				case ($urandom_range(0, 5))
					0: beat = mk_update(bpvr_pkg::VENUE_W'($urandom), '0, bid, ask);
					1: begin
						bid = $urandom_range(0, 1) ? px_t'(0) : px_t'($urandom | 32'h8000_0000);
						beat = mk_update(bpvr_pkg::VENUE_W'($urandom), sym, bid, ask);
					end
					2: begin
						ask = $urandom_range(0, 1) ? px_t'(0) : px_t'($urandom | 32'h8000_0000);
						beat = mk_update(bpvr_pkg::VENUE_W'($urandom), sym, bid, ask);
					end
					3: begin
						hi = $urandom_range(2, 32'h7FFF_FFFF);
						beat = mk_update(bpvr_pkg::VENUE_W'($urandom), sym, px_t'(hi),
							px_t'($urandom_range(1, hi - 1)));
					end
					4: beat = mk_route(bpvr_pkg::SYMBOL_W'($urandom), 1'($urandom), $urandom);
					default: beat = any_beat();
				endcase
			end
			queue_order(beat, quiet);
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Drain: every beat sent and answered, then let the pipe settle.
		while (orders_taken < order_total || answers_due.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		if (mismatch_count == 0 && answers_due.size() == 0)
			$display("best_price_venue_router_top verification clean");
		else
			$display("best_price_venue_router_top verification failed");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run, including the clearing pass after reset.
	initial begin : watchdog
		#1_000_000;
		$display("best_price_venue_router_top verification failed");
		$finish;
	end

endmodule
